// ===== hdl/modbus_rtu_request_frame_parser_macros.svh =====
// Assertion macros for the Modbus RTU request-frame parser
`ifndef MODBUS_RTU_REQUEST_FRAME_PARSER_MACROS_SVH
`define MODBUS_RTU_REQUEST_FRAME_PARSER_MACROS_SVH

`ifndef ASSERT_OFF

`define MRFP_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("mrfp assertion failed");

`define MRFP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mrfp implication failed");

`else

`define MRFP_ASSERT(lbl, cond)

`define MRFP_ASSERT_IMP(lbl, ante, cons)

`endif

`endif

// ===== hdl/mrfp_pkg.sv =====
// Package: types, constants and CRC function of the Modbus RTU request-frame parser
`timescale 1ns / 1ps
`default_nettype none
package mrfp_pkg;

	localparam int unsigned TdataOutW = 40;

	localparam logic [7:0] MaxDataBytes = 8'd252;
	localparam logic [7:0] FixedDataLen = 8'd4;
	localparam logic [7:0] WriteHdrLen = 8'd5;
	localparam logic [7:0] ByteCountPos = 8'd4;

	localparam logic [7:0] FnReadHolding = 8'd3;
	localparam logic [7:0] FnWriteSingle = 8'd6;
	localparam logic [7:0] FnWriteMulti = 8'd16;

	localparam logic [15:0] CrcInit = 16'hFFFF;
	localparam logic [15:0] CrcPoly = 16'hA001;

	localparam logic [7:0] AddrAReset = 8'd1;
	localparam logic [7:0] AddrBReset = 8'd2;
	localparam logic [7:0] AddrCReset = 8'd3;

	localparam logic [1:0] CfgAddrA = 2'd0;
	localparam logic [1:0] CfgAddrB = 2'd1;
	localparam logic [1:0] CfgAddrC = 2'd2;

	typedef enum logic [2:0] {
		PH_ADDR = 3'd0,
		PH_FUNC = 3'd1,
		PH_DATA = 3'd2,
		PH_CRCL = 3'd3,
		PH_CRCH = 3'd4,
		PH_GOOD = 3'd5
	} phase_t;

	typedef struct packed {
		logic [7:0] frame_function;
		logic [7:0] frame_address;
		logic [7:0] stored_value;
		logic [7:0] stored_index;
		logic       stored_flag;
		logic [2:0] parse_status;
	} result_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/mrfp_parser.sv =====
// Parser state registers and the per-byte frame step with CRC update
`timescale 1ns / 1ps
`default_nettype none
module mrfp_parser (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic [7:0]       rx_byte,
	input  wire logic [7:0]       addr_a,
	input  wire logic [7:0]       addr_b,
	input  wire logic [7:0]       addr_c,
	output mrfp_pkg::result_t     res
);
	import mrfp_pkg::*;

	phase_t      phase_q, phase_d, ph_eff;
	logic [7:0]  addr_q, addr_d;
	logic [7:0]  func_q, func_d;
	logic [7:0]  dc_q, dc_d, dc_inc;
	logic [7:0]  wbc_q, wbc_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  crcl_q, crcl_d;
	logic        addr_hit, fn_ok, end16;
	logic [15:0] addr_crc, step_crc;

	assign addr_hit = (rx_byte == addr_a) || (rx_byte == addr_b) || (rx_byte == addr_c);
	assign fn_ok    = (rx_byte == FnReadHolding) || (rx_byte == FnWriteSingle) ||
			(rx_byte == FnWriteMulti);
	assign addr_crc = crc_byte(CrcInit, rx_byte);
	assign step_crc = crc_byte(crc_q, rx_byte);
	assign dc_inc   = dc_q + 8'd1;
	assign ph_eff   = (phase_q == PH_GOOD || phase_q > PH_GOOD) ? PH_ADDR : phase_q;

	always_comb begin
		phase_d = ph_eff;
		addr_d  = addr_q;
		func_d  = func_q;
		dc_d    = dc_q;
		wbc_d   = wbc_q;
		crc_d   = crc_q;
		crcl_d  = crcl_q;
		end16   = 1'b0;
		res.stored_flag  = 1'b0;
		res.stored_index = 8'd0;
		res.stored_value = 8'd0;
		unique case (ph_eff)
			PH_FUNC: begin
				func_d = rx_byte;
				dc_d   = 8'd0;
				if (fn_ok) begin
					crc_d   = step_crc;
					phase_d = PH_DATA;
				end else begin
					addr_d  = rx_byte;
					crc_d   = addr_crc;
					phase_d = addr_hit ? PH_FUNC : PH_ADDR;
				end
			end
			PH_DATA: begin
				res.stored_flag  = 1'b1;
				res.stored_index = dc_q;
				res.stored_value = rx_byte;
				if (dc_q == ByteCountPos)
					wbc_d = rx_byte;
				dc_d  = dc_inc;
				crc_d = step_crc;
				end16 = (dc_inc >= WriteHdrLen) &&
						({1'b0, dc_inc} >= ({1'b0, wbc_d} + {1'b0, WriteHdrLen}));
				if (func_q == FnWriteMulti) begin
					if (end16)
						phase_d = PH_CRCL;
				end else if (dc_inc >= FixedDataLen) begin
					phase_d = PH_CRCL;
				end
				if (dc_inc >= MaxDataBytes)
					phase_d = PH_ADDR;
			end
			PH_CRCL: begin
				crcl_d           = rx_byte;
				res.stored_flag  = 1'b1;
				res.stored_index = dc_q;
				res.stored_value = rx_byte;
				dc_d             = dc_inc;
				phase_d          = PH_CRCH;
			end
			PH_CRCH: begin
				res.stored_flag  = 1'b1;
				res.stored_index = dc_q;
				res.stored_value = rx_byte;
				dc_d             = dc_inc;
				phase_d = (crcl_q == crc_q[7:0] && rx_byte == crc_q[15:8]) ? PH_GOOD : PH_ADDR;
			end
			default: begin
				addr_d  = rx_byte;
				crc_d   = addr_crc;
				phase_d = addr_hit ? PH_FUNC : PH_ADDR;
			end
		endcase
		res.parse_status   = phase_d;
		res.frame_address  = addr_d;
		res.frame_function = func_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ADDR;
			addr_q  <= 8'd0;
			func_q  <= 8'd0;
			dc_q    <= 8'd0;
			wbc_q   <= 8'd0;
			crc_q   <= CrcInit;
			crcl_q  <= 8'd0;
		end else if (adv) begin
			phase_q <= phase_d;
			addr_q  <= addr_d;
			func_q  <= func_d;
			dc_q    <= dc_d;
			wbc_q   <= wbc_d;
			crc_q   <= crc_d;
			crcl_q  <= crcl_d;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/mrfp_out_stage.sv =====
// Result register with valid/ready hold toward the downstream receiver
`timescale 1ns / 1ps
`default_nettype none
module mrfp_out_stage (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     ld,
	input  wire mrfp_pkg::result_t        res,
	input  wire logic                     ready,
	output logic                          valid,
	output logic [mrfp_pkg::TdataOutW-1:0] data
);
	import mrfp_pkg::*;

	logic    valid_q;
	result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ld) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld)
			res_q <= res;
	end

	assign valid = valid_q;
	assign data  = {{(TdataOutW - $bits(result_t)){1'b0}}, res_q};

endmodule
`default_nettype wire

// ===== hdl/modbus_rtu_request_frame_parser.sv =====
// Top level: Modbus RTU request-frame parser with address registers and stream ports
//
// Usage:
//   Slave stream s_* carries one received byte per item (s_tdata[7:0]).
//   Master stream m_* carries one status item for every byte taken.
//   cfg_we/cfg_index/cfg_data write the three accepted slave addresses
//   (index 0, 1, 2); other indexes are ignored. Write only while idle.
// Timing:
//   A byte goes into an input register, then the parser step (phase
//   update and one byte of CRC-16) runs between that register and the
//   result register; m_tvalid rises when the result register loads.
//   Throughput is one item per cycle while m_tready is held high.
// Reset:
//   arst_n clears both stages, puts the parser in await-address with the
//   CRC at 0xFFFF, and loads addresses 1, 2 and 3.
// Stall:
//   If m_tready is low the result holds; one more byte may sit in the
//   input register, after which s_tready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "modbus_rtu_request_frame_parser_macros.svh"
module modbus_rtu_request_frame_parser (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [7:0]                   s_tdata,  // [7:0] rx_byte
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// [2:0] parse_status, [3] stored_flag, [11:4] stored_index,
	// [19:12] stored_value, [27:20] frame_address, [35:28] frame_function, [39:36] zero
	output logic [mrfp_pkg::TdataOutW-1:0]    m_tdata,
	input  wire logic                         cfg_we,
	input  wire logic [1:0]                   cfg_index,
	input  wire logic [7:0]                   cfg_data
);
	import mrfp_pkg::*;

	logic       in_valid_s1;
	logic [7:0] in_byte_s1;
	logic       adv;
	logic [7:0] addr_a_q, addr_b_q, addr_c_q;
	result_t    step_res;

	assign adv      = in_valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !in_valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_a_q <= AddrAReset;
			addr_b_q <= AddrBReset;
			addr_c_q <= AddrCReset;
		end else if (cfg_we) begin
			if (cfg_index == CfgAddrA)
				addr_a_q <= cfg_data;
			if (cfg_index == CfgAddrB)
				addr_b_q <= cfg_data;
			if (cfg_index == CfgAddrC)
				addr_c_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			in_byte_s1 <= s_tdata;
	end

	mrfp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.rx_byte (in_byte_s1),
		.addr_a  (addr_a_q),
		.addr_b  (addr_b_q),
		.addr_c  (addr_c_q),
		.res     (step_res)
	);

	mrfp_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.ld     (adv),
		.res    (step_res),
		.ready  (m_tready),
		.valid  (m_tvalid),
		.data   (m_tdata)
	);

	`MRFP_ASSERT_IMP(a_ready_when_out_empty, !m_tvalid, s_tready)
	`MRFP_ASSERT_IMP(a_status_range, m_tvalid, m_tdata[2:0] <= PH_GOOD)
	`MRFP_ASSERT_IMP(a_unstored_zero, m_tvalid && !m_tdata[3], m_tdata[19:4] == 16'd0)
	`MRFP_ASSERT_IMP(a_good_is_stored, m_tvalid && m_tdata[2:0] == PH_GOOD, m_tdata[3])

endmodule
`default_nettype wire
